// ----- rtl/core/sgr_pkg.sv -----
package sgr_pkg;

   // Field and register widths.
   localparam int OP_W       = 2;
   localparam int POS_W      = 7;
   localparam int CELL_W     = 16;
   localparam int TH_W       = 11;
   localparam int PASS_W     = 16;
   localparam int TOTAL_W    = 32;
   localparam int OCC_OUT_W  = 15;
   localparam int CSR_IDX_W  = 4;
   localparam int CSR_DATA_W = 16;
   localparam int DIV_CNT_W  = $clog2(CELL_W);

   // Saturation limits, clamp values and reset values.
   localparam logic [CELL_W-1:0]    CELL_MAX  = '1;
   localparam logic [TOTAL_W-1:0]   TOTAL_MAX = '1;
   localparam logic [OCC_OUT_W-1:0] OCC_MAX   = '1;
   localparam logic [TH_W-1:0]      TH_MIN    = TH_W'(2);
   localparam logic [TH_W-1:0]      TH_RESET  = TH_W'(4);
   localparam logic [PASS_W-1:0]    LIM_RESET = PASS_W'(1024);

   // Operation codes.
   localparam logic [OP_W-1:0] OP_DROP   = 2'd0;
   localparam logic [OP_W-1:0] OP_TOPPLE = 2'd1;
   localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;
   localparam logic [OP_W-1:0] OP_NONE   = 2'd3;

   // Register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_THRESHOLD  = 4'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_PASSES = 4'd1;

   // Sequencer states.
   typedef enum logic [3:0] {
      ST_INIT,
      ST_IDLE,
      ST_CLEAR,
      ST_DROP_IDX,
      ST_DROP_RD,
      ST_DROP_WR,
      ST_PASS_START,
      ST_CELL_RD,
      ST_CELL_CHK,
      ST_DIV,
      ST_CELL_WR,
      ST_NB_SEL,
      ST_NB_WR,
      ST_CELL_NEXT,
      ST_PASS_END,
      ST_DONE
   } state_type;

endpackage

// ----- rtl/core/sgr_ram.sv -----
module sgr_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 16384
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // One write port and one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

// ----- rtl/core/sandpile_grid_relaxer.sv -----
// Topple: each pass reads every cell in raster order; a firing cell runs the 16-step shared
// divider, then up to four neighbour read-modify-writes through the single grid memory.
// Throughput: one operation at a time; the request side stalls until the result is registered.
// Reset: synchronous; afterwards a sweep through every cell zeroes the grid.
module sandpile_grid_relaxer #(
   parameter int GRID_WIDTH  = 128,
   parameter int GRID_HEIGHT = 128
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [sgr_pkg::OP_W-1:0]          req_operation,
   input  logic [sgr_pkg::POS_W-1:0]         req_x_pos,
   input  logic [sgr_pkg::POS_W-1:0]         req_y_pos,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [sgr_pkg::TOTAL_W-1:0]       rsp_topple_total,
   output logic [sgr_pkg::PASS_W-1:0]        rsp_passes_used,
   output logic                              rsp_limit_hit,
   output logic [sgr_pkg::OCC_OUT_W-1:0]     rsp_occupied_cells,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [sgr_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [sgr_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   import sgr_pkg::*;

   localparam int CELLS  = GRID_WIDTH * GRID_HEIGHT;
   localparam int ADDR_W = $clog2(CELLS);
   localparam int COL_W  = $clog2(GRID_WIDTH);
   localparam int ROW_W  = $clog2(GRID_HEIGHT);
   localparam int OCC_W  = $clog2(CELLS + 1);

   localparam logic [ADDR_W-1:0] LAST_IDX = ADDR_W'(CELLS - 1);
   localparam logic [ADDR_W-1:0] ROW_STEP = ADDR_W'(GRID_WIDTH);
   localparam logic [COL_W-1:0]  LAST_COL = COL_W'(GRID_WIDTH - 1);
   localparam logic [ROW_W-1:0]  LAST_ROW = ROW_W'(GRID_HEIGHT - 1);

   // Neighbour visiting order.
   localparam logic [1:0] NB_LEFT  = 2'd0;
   localparam logic [1:0] NB_RIGHT = 2'd1;
   localparam logic [1:0] NB_UP    = 2'd2;
   localparam logic [1:0] NB_DOWN  = 2'd3;

   state_type               state_ff, state_in;
   logic [TH_W-1:0]         cfg_th_ff, cfg_th_in;
   logic [PASS_W-1:0]       cfg_lim_ff, cfg_lim_in;
   logic [TH_W-1:0]         th_ff, th_in;
   logic [PASS_W-1:0]       lim_ff, lim_in;
   logic [POS_W-1:0]        x_ff, x_in;
   logic [POS_W-1:0]        y_ff, y_in;
   logic [ADDR_W-1:0]       idx_ff, idx_in;
   logic [COL_W-1:0]        col_ff, col_in;
   logic [ROW_W-1:0]        row_ff, row_in;
   logic [1:0]              nb_ff, nb_in;
   logic [CELL_W-1:0]       div_q_ff, div_q_in;
   logic [TH_W-1:0]         div_rem_ff, div_rem_in;
   logic [DIV_CNT_W-1:0]    div_cnt_ff, div_cnt_in;
   logic [TOTAL_W-1:0]      total_ff, total_in;
   logic [PASS_W-1:0]       passes_ff, passes_in;
   logic                    fired_ff, fired_in;
   logic                    hit_ff, hit_in;
   logic [OCC_W-1:0]        occ_ff, occ_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [TOTAL_W-1:0]      rsp_total_ff, rsp_total_in;
   logic [PASS_W-1:0]       rsp_passes_ff, rsp_passes_in;
   logic                    rsp_hit_ff, rsp_hit_in;
   logic [OCC_OUT_W-1:0]    rsp_occ_ff, rsp_occ_in;

   logic                    ram_we;
   logic [ADDR_W-1:0]       ram_waddr;
   logic [CELL_W-1:0]       ram_wdata;
   logic [ADDR_W-1:0]       ram_raddr;
   logic [CELL_W-1:0]       ram_rdata;

   logic                    req_accept;
   logic                    rsp_free;
   logic                    last_cell;
   logic [ADDR_W-1:0]       idx_next;
   logic [COL_W-1:0]        col_next;
   logic [ROW_W-1:0]        row_next;
   logic                    cell_fires;
   logic                    nb_exists;
   logic [ADDR_W-1:0]       nb_addr;
   logic [CELL_W:0]         sat_sum;
   logic [CELL_W-1:0]       sat_value;
   logic [TH_W:0]           div_trial;
   logic                    div_bit;
   logic [TOTAL_W:0]        total_sum;
   logic                    drop_in_grid;
   logic [31:0]             drop_idx;
   logic                    more_passes;
   logic [31:0]             occ_wide;
   logic [OCC_OUT_W-1:0]    occ_report;

   sgr_ram #(
      .WIDTH (CELL_W),
      .DEPTH (CELLS)
   ) u_grid (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   // Handshake signals.
   assign req_accept = req_valid && !req_stall;
   assign req_stall  = (state_ff != ST_IDLE);
   assign rsp_free   = !rsp_valid_ff || !rsp_stall;
   assign csr_ready  = 1'b1;

   // Raster position helpers.
   assign last_cell = (idx_ff == LAST_IDX);
   assign idx_next  = idx_ff + ADDR_W'(1);
   assign col_next  = (col_ff == LAST_COL) ? '0 : col_ff + COL_W'(1);
   assign row_next  = (col_ff == LAST_COL) ? row_ff + ROW_W'(1) : row_ff;
   assign cell_fires = (ram_rdata >= CELL_W'(th_ff));

   // Neighbour selection for the cell being fired.
   always_comb begin
      nb_exists = 1'b0;
      nb_addr   = idx_ff;
      unique case (nb_ff)
         NB_LEFT: begin
            nb_exists = (col_ff != '0);
            nb_addr   = idx_ff - ADDR_W'(1);
         end
         NB_RIGHT: begin
            nb_exists = (col_ff != LAST_COL);
            nb_addr   = idx_ff + ADDR_W'(1);
         end
         NB_UP: begin
            nb_exists = (row_ff != '0);
            nb_addr   = idx_ff - ROW_STEP;
         end
         NB_DOWN: begin
            nb_exists = (row_ff != LAST_ROW);
            nb_addr   = idx_ff + ROW_STEP;
         end
         default: begin
            nb_exists = 1'b0;
            nb_addr   = idx_ff;
         end
      endcase
   end

   // Shared saturating adder for drops and neighbour grains.
   assign sat_sum   = {1'b0, ram_rdata} + {1'b0, div_q_ff};
   assign sat_value = sat_sum[CELL_W] ? CELL_MAX : sat_sum[CELL_W-1:0];

   // One restoring division step per cycle.
   assign div_trial = {div_rem_ff, div_q_ff[CELL_W-1]};
   assign div_bit   = (div_trial >= {1'b0, th_ff});

   // Saturating firing total.
   assign total_sum = {1'b0, total_ff} + (TOTAL_W + 1)'(div_q_ff);

   // Drop address.
   assign drop_in_grid = (32'(x_ff) < 32'(GRID_WIDTH)) && (32'(y_ff) < 32'(GRID_HEIGHT));
   assign drop_idx     = 32'(y_ff) * 32'(GRID_WIDTH) + 32'(x_ff);

   // Another pass runs if this one fired and the limit allows.
   assign more_passes = fired_ff &&
                        (({1'b0, passes_ff} + (PASS_W + 1)'(1)) < {1'b0, lim_ff});

   // Occupied count as reported, saturated to the field.
   assign occ_wide   = 32'(occ_ff);
   assign occ_report = (occ_wide >= 32'(OCC_MAX)) ? OCC_MAX : occ_wide[OCC_OUT_W-1:0];

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_INIT: begin
            if (last_cell) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_accept) begin
               unique case (req_operation)
                  OP_DROP:   state_in = ST_DROP_IDX;
                  OP_TOPPLE: state_in = ST_PASS_START;
                  OP_CLEAR:  state_in = ST_CLEAR;
                  OP_NONE:   state_in = ST_DONE;
                  default:   state_in = ST_DONE;
               endcase
            end
         end
         ST_CLEAR: begin
            if (last_cell) begin
               state_in = ST_DONE;
            end
         end
         ST_DROP_IDX:   state_in = drop_in_grid ? ST_DROP_RD : ST_DONE;
         ST_DROP_RD:    state_in = ST_DROP_WR;
         ST_DROP_WR:    state_in = ST_DONE;
         ST_PASS_START: state_in = ST_CELL_RD;
         ST_CELL_RD:    state_in = ST_CELL_CHK;
         ST_CELL_CHK: begin
            if (cell_fires) begin
               state_in = ST_DIV;
            end else if (last_cell) begin
               state_in = ST_PASS_END;
            end
         end
         ST_DIV: begin
            if (div_cnt_ff == DIV_CNT_W'(CELL_W - 1)) begin
               state_in = ST_CELL_WR;
            end
         end
         ST_CELL_WR: state_in = ST_NB_SEL;
         ST_NB_SEL: begin
            if (nb_exists) begin
               state_in = ST_NB_WR;
            end else if (nb_ff == NB_DOWN) begin
               state_in = ST_CELL_NEXT;
            end
         end
         ST_NB_WR:     state_in = (nb_ff == NB_DOWN) ? ST_CELL_NEXT : ST_NB_SEL;
         ST_CELL_NEXT: state_in = last_cell ? ST_PASS_END : ST_CELL_RD;
         ST_PASS_END:  state_in = more_passes ? ST_PASS_START : ST_DONE;
         ST_DONE: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Datapath, memory port and result register.
   always_comb begin
      th_in         = th_ff;
      lim_in        = lim_ff;
      x_in          = x_ff;
      y_in          = y_ff;
      idx_in        = idx_ff;
      col_in        = col_ff;
      row_in        = row_ff;
      nb_in         = nb_ff;
      div_q_in      = div_q_ff;
      div_rem_in    = div_rem_ff;
      div_cnt_in    = div_cnt_ff;
      total_in      = total_ff;
      passes_in     = passes_ff;
      fired_in      = fired_ff;
      hit_in        = hit_ff;
      occ_in        = occ_ff;
      rsp_total_in  = rsp_total_ff;
      rsp_passes_in = rsp_passes_ff;
      rsp_hit_in    = rsp_hit_ff;
      rsp_occ_in    = rsp_occ_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      ram_we        = 1'b0;
      ram_waddr     = idx_ff;
      ram_wdata     = '0;
      ram_raddr     = idx_ff;

      unique case (state_ff)
         ST_INIT, ST_CLEAR: begin
            ram_we = 1'b1;
            idx_in = last_cell ? '0 : idx_next;
         end
         ST_IDLE: begin
            if (req_accept) begin
               th_in     = (cfg_th_ff < TH_MIN) ? TH_MIN : cfg_th_ff;
               lim_in    = (cfg_lim_ff == '0) ? PASS_W'(1) : cfg_lim_ff;
               x_in      = req_x_pos;
               y_in      = req_y_pos;
               idx_in    = '0;
               div_q_in  = CELL_W'(1);
               total_in  = '0;
               passes_in = '0;
               hit_in    = 1'b0;
               if (req_operation == OP_CLEAR) begin
                  occ_in = '0;
               end
            end
         end
         ST_DROP_IDX: begin
            idx_in = drop_idx[ADDR_W-1:0];
         end
         ST_DROP_RD: begin
            ram_raddr = idx_ff;
         end
         ST_DROP_WR: begin
            ram_we    = 1'b1;
            ram_wdata = sat_value;
            if (ram_rdata == '0) begin
               occ_in = occ_ff + OCC_W'(1);
            end
         end
         ST_PASS_START: begin
            idx_in   = '0;
            col_in   = '0;
            row_in   = '0;
            fired_in = 1'b0;
         end
         ST_CELL_RD: begin
            ram_raddr = idx_ff;
         end
         ST_CELL_CHK: begin
            // A quiet cell moves straight on to the next read.
            if (cell_fires) begin
               div_q_in   = ram_rdata;
               div_rem_in = '0;
               div_cnt_in = '0;
            end else if (!last_cell) begin
               ram_raddr = idx_next;
               idx_in    = idx_next;
               col_in    = col_next;
               row_in    = row_next;
            end
         end
         ST_DIV: begin
            div_q_in   = {div_q_ff[CELL_W-2:0], div_bit};
            div_rem_in = div_bit ? TH_W'(div_trial - {1'b0, th_ff}) : div_trial[TH_W-1:0];
            div_cnt_in = div_cnt_ff + DIV_CNT_W'(1);
         end
         ST_CELL_WR: begin
            ram_we    = 1'b1;
            ram_wdata = CELL_W'(div_rem_ff);
            total_in  = total_sum[TOTAL_W] ? TOTAL_MAX : total_sum[TOTAL_W-1:0];
            fired_in  = 1'b1;
            nb_in     = NB_LEFT;
            if (div_rem_ff == '0) begin
               occ_in = occ_ff - OCC_W'(1);
            end
         end
         ST_NB_SEL: begin
            ram_raddr = nb_addr;
            if (!nb_exists) begin
               nb_in = nb_ff + 2'd1;
            end
         end
         ST_NB_WR: begin
            ram_we    = 1'b1;
            ram_waddr = nb_addr;
            ram_wdata = sat_value;
            nb_in     = nb_ff + 2'd1;
            if (ram_rdata == '0) begin
               occ_in = occ_ff + OCC_W'(1);
            end
         end
         ST_CELL_NEXT: begin
            if (!last_cell) begin
               idx_in = idx_next;
               col_in = col_next;
               row_in = row_next;
            end
         end
         ST_PASS_END: begin
            passes_in = passes_ff + PASS_W'(1);
            hit_in    = fired_ff;
         end
         ST_DONE: begin
            if (rsp_free) begin
               rsp_valid_in  = 1'b1;
               rsp_total_in  = total_ff;
               rsp_passes_in = passes_ff;
               rsp_hit_in    = hit_ff;
               rsp_occ_in    = occ_report;
            end
         end
         default: begin
            ram_we = 1'b0;
         end
      endcase
   end

   // Configuration registers.
   always_comb begin
      cfg_th_in  = cfg_th_ff;
      cfg_lim_in = cfg_lim_ff;
      if (csr_valid && csr_ready) begin
         if (csr_index == CSR_THRESHOLD) begin
            cfg_th_in = csr_wdata[TH_W-1:0];
         end else if (csr_index == CSR_MAX_PASSES) begin
            cfg_lim_in = csr_wdata[PASS_W-1:0];
         end
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         idx_ff       <= '0;
         occ_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         cfg_th_ff    <= TH_RESET;
         cfg_lim_ff   <= LIM_RESET;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         occ_ff       <= occ_in;
         rsp_valid_ff <= rsp_valid_in;
         cfg_th_ff    <= cfg_th_in;
         cfg_lim_ff   <= cfg_lim_in;
      end
   end

   // Working and result payload registers.
   always_ff @(posedge clock) begin
      th_ff         <= th_in;
      lim_ff        <= lim_in;
      x_ff          <= x_in;
      y_ff          <= y_in;
      col_ff        <= col_in;
      row_ff        <= row_in;
      nb_ff         <= nb_in;
      div_q_ff      <= div_q_in;
      div_rem_ff    <= div_rem_in;
      div_cnt_ff    <= div_cnt_in;
      total_ff      <= total_in;
      passes_ff     <= passes_in;
      fired_ff      <= fired_in;
      hit_ff        <= hit_in;
      rsp_total_ff  <= rsp_total_in;
      rsp_passes_ff <= rsp_passes_in;
      rsp_hit_ff    <= rsp_hit_in;
      rsp_occ_ff    <= rsp_occ_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_topple_total   = rsp_total_ff;
   assign rsp_passes_used    = rsp_passes_ff;
   assign rsp_limit_hit      = rsp_hit_ff;
   assign rsp_occupied_cells = rsp_occ_ff;

endmodule

// ----- rtl/core/sgr_checker.sv -----
module sgr_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_valid,
   input logic                              req_stall,
   input logic [sgr_pkg::OP_W-1:0]          req_operation,
   input logic [sgr_pkg::POS_W-1:0]         req_x_pos,
   input logic [sgr_pkg::POS_W-1:0]         req_y_pos,
   input logic                              rsp_valid,
   input logic                              rsp_stall,
   input logic [sgr_pkg::TOTAL_W-1:0]       rsp_topple_total,
   input logic [sgr_pkg::PASS_W-1:0]        rsp_passes_used,
   input logic                              rsp_limit_hit,
   input logic [sgr_pkg::OCC_OUT_W-1:0]     rsp_occupied_cells,
   input logic                              csr_valid,
   input logic                              csr_ready,
   input logic [sgr_pkg::CSR_IDX_W-1:0]     csr_index,
   input logic [sgr_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   import sgr_pkg::*;

   // The grid is swept clear after reset, so no request is taken straight away.
   a_busy_after_reset: assert property (@(posedge clock)
      reset |=> req_stall)
      else $error("request side open straight after reset");

   // One operation at a time: the block is busy after taking a transaction.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("request taken while previous operation still running");

   // Only a topple runs passes; every other result has no firings and no limit flag.
   a_non_topple_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_passes_used == '0) |-> (rsp_topple_total == '0 && !rsp_limit_hit))
      else $error("firings reported for an operation that ran no pass");

   // Hitting the pass limit means the last pass fired.
   a_limit_fired: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_limit_hit) |-> (rsp_topple_total != '0 && rsp_passes_used != '0))
      else $error("pass limit flagged without any firing");

   // A stalled result transaction holds.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_topple_total) &&
         $stable(rsp_passes_used) && $stable(rsp_limit_hit) && $stable(rsp_occupied_cells)))
      else $error("stalled result changed");

endmodule

bind sandpile_grid_relaxer sgr_checker u_sgr_checker (.*);
